// ----- sv/dfsts_pkg.sv -----
// ----------------------------------------------------------------------------
// dfsts_pkg
// Shared types and constants for the depth-first search timestamp block:
// command codes, timestamp width and the stack control/status structs.
// ----------------------------------------------------------------------------
package dfsts_pkg;

    // command codes carried in the kind field
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_EDGE = 2'd1;
    localparam logic [1:0] KIND_RUN  = 2'd2;

    // field widths fixed by the interface
    localparam int KIND_W = 2;
    localparam int IDX_W  = 5;
    localparam int TIME_W = 7;

    // the time counter saturates here
    localparam logic [TIME_W-1:0] TIME_MAX = 7'd127;

    // stack commands from the sequencer
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stk_ctl_t;

    // stack status back to the sequencer
    typedef struct packed {
        logic empty;
        logic single;
    } stk_sts_t;

endpackage

// ----- sv/dfsts_ifs.sv -----
// ----------------------------------------------------------------------------
// dfsts_ifs
// Valid/ready channels of the search block: command words in, per-vertex
// timestamp words out.
// ----------------------------------------------------------------------------
interface dfsts_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [dfsts_pkg::KIND_W-1:0] kind;
    logic [dfsts_pkg::IDX_W-1:0]  vertex;
    logic [dfsts_pkg::IDX_W-1:0]  neighbor;

    modport source (output valid, kind, vertex, neighbor, input ready);
    modport sink   (input valid, kind, vertex, neighbor, output ready);
endinterface

interface dfsts_res_if;
    logic                         valid;
    logic                         ready;
    logic [dfsts_pkg::IDX_W-1:0]  node;
    logic [dfsts_pkg::TIME_W-1:0] first_seen;
    logic [dfsts_pkg::TIME_W-1:0] finished;
    logic                         edges_dropped;
    logic                         last;

    modport source (output valid, node, first_seen, finished, edges_dropped, last,
                    input ready);
    modport sink   (input valid, node, first_seen, finished, edges_dropped, last,
                    output ready);
endinterface

// ----- sv/dfsts_stack.sv -----
// ----------------------------------------------------------------------------
// dfsts_stack
// Walk stack of vertex indices: one memory, a top pointer and a registered
// read of the top entry. Pushes onto a full stack are dropped.
// ----------------------------------------------------------------------------
module dfsts_stack #(
    parameter int DEPTH = 256,
    parameter int DW    = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dfsts_pkg::stk_ctl_t ctl,
    input  logic [DW-1:0]       push_data,
    output logic [DW-1:0]       top_data,
    output dfsts_pkg::stk_sts_t sts
);
    import dfsts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int TW = $clog2(DEPTH + 1);
    localparam logic [TW-1:0] FULL_CNT = TW'(DEPTH);

    logic [DW-1:0] mem [DEPTH];
    logic [TW-1:0] top_reg;
    logic [TW-1:0] top_next;
    logic [TW-1:0] top_m1;
    logic          full;

    assign full   = (top_reg == FULL_CNT);
    assign top_m1 = top_reg - TW'(1);

    // pointer update
    always_comb
    begin
        top_next = top_reg;
        if (ctl.clear)
        begin
            top_next = '0;
        end
        else if (ctl.push && !full)
        begin
            top_next = top_reg + TW'(1);
        end
        else if (ctl.pop)
        begin
            top_next = top_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else
        begin
            top_reg <= top_next;
        end
    end

    // storage: write on push, registered read of the current top
    always_ff @(posedge clk)
    begin
        if (ctl.push && !full && !ctl.clear)
        begin
            mem[top_reg[AW-1:0]] <= push_data;
        end
        top_data <= mem[top_m1[AW-1:0]];
    end

    assign sts.empty  = (top_reg == '0);
    assign sts.single = (top_reg == TW'(1));

endmodule

// ----- sv/depth_first_search_timestamps.sv -----
// ----------------------------------------------------------------------------
// depth_first_search_timestamps
// Graph store plus a stack-driven depth-first search that reports discovery
// and finish times for every present vertex.
// ----------------------------------------------------------------------------
// Add-vertex and append-edge words are taken while idle. A run word starts a
// sequencer that walks the graph through one stack memory and one neighbour
// memory, each with a registered read: each root candidate is checked in
// turn; each visited vertex has its top read, a check, a read and a check per
// list entry and its discovery stamp; every further stack entry is read,
// checked and popped. The report then scans the vertices, loading each
// present one and holding while the output register is not taken.
// Input is not accepted while a run is in progress; the last result may still
// wait in the output register when the next word is taken.
module depth_first_search_timestamps #(
    parameter int VERTICES    = 32,
    parameter int MAX_DEGREE  = 4,
    parameter int STACK_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    dfsts_cmd_if.sink   cmd,
    dfsts_res_if.source res
);
    import dfsts_pkg::*;

    localparam int VW    = $clog2(VERTICES);
    localparam int LW    = $clog2(MAX_DEGREE + 1);
    localparam int NA    = VERTICES * MAX_DEGREE;
    localparam int NAW   = $clog2(NA);
    localparam int REP_N = (VERTICES < 32) ? VERTICES : 32;
    localparam int RW    = $clog2(REP_N + 1);
    localparam logic [VW:0]   ROOT_END = (VW+1)'(VERTICES);
    localparam logic [RW-1:0] REP_END  = RW'(REP_N);
    localparam logic [LW-1:0] DEG_MAX  = LW'(MAX_DEGREE);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_ROOT     = 10'b00_0000_0010,
        ST_TOP_RD   = 10'b00_0000_0100,
        ST_CHECK    = 10'b00_0000_1000,
        ST_NB_RD    = 10'b00_0001_0000,
        ST_NB_CHK   = 10'b00_0010_0000,
        ST_DISC     = 10'b00_0100_0000,
        ST_POP      = 10'b00_1000_0000,
        ST_REP_SCAN = 10'b01_0000_0000,
        ST_REP_LOAD = 10'b10_0000_0000
    } state_t;

    // control state
    state_t              state_reg, state_next;
    logic [VW:0]         root_reg, root_next;
    logic [VW-1:0]       cur_reg, cur_next;
    logic [LW-1:0]       nbi_reg, nbi_next;
    logic                pushed_reg, pushed_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [RW-1:0]       rep_reg, rep_next;
    logic [VERTICES-1:0] present_reg, present_next;
    logic [VERTICES-1:0] visited_reg, visited_next;
    logic [VERTICES-1:0] finished_reg, finished_next;
    logic [LW-1:0]       len_reg [VERTICES];
    logic [LW-1:0]       len_next [VERTICES];
    logic                dropped_reg, dropped_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    node_reg, node_next;
    logic [TIME_W-1:0]   first_reg, first_next;
    logic [TIME_W-1:0]   fin_reg, fin_next;
    logic                drop_out_reg, drop_out_next;
    logic                last_reg, last_next;

    // memories
    logic [VW-1:0]       nbr_mem [NA];
    logic [TIME_W-1:0]   disc_mem [VERTICES];
    logic [TIME_W-1:0]   fin_mem [VERTICES];
    logic [VW-1:0]       nbr_q;
    logic [TIME_W-1:0]   disc_q;
    logic [TIME_W-1:0]   fin_q;
    logic                nbr_we;
    logic [NAW-1:0]      nbr_waddr;
    logic [NAW-1:0]      nbr_raddr;
    logic                disc_we;
    logic                fin_we;

    // stack
    stk_ctl_t            stk_ctl;
    stk_sts_t            stk_sts;
    logic [VW-1:0]       stk_wdata;
    logic [VW-1:0]       stk_top;

    // helpers
    logic [VW-1:0]       cmd_v;
    logic [VW-1:0]       cmd_n;
    logic                cmd_v_ok;
    logic                cmd_n_ok;
    logic [VW-1:0]       root_i;
    logic [VW-1:0]       rep_i;
    logic [TIME_W-1:0]   time_inc;
    logic                any_above;
    logic                out_free;

    dfsts_stack #(
        .DEPTH (STACK_DEPTH),
        .DW    (VW)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (stk_ctl),
        .push_data (stk_wdata),
        .top_data  (stk_top),
        .sts       (stk_sts)
    );

    assign cmd_v    = VW'(cmd.vertex);
    assign cmd_n    = VW'(cmd.neighbor);
    assign cmd_v_ok = (32'(cmd.vertex) < 32'(VERTICES));
    assign cmd_n_ok = (32'(cmd.neighbor) < 32'(VERTICES));
    assign root_i   = root_reg[VW-1:0];
    assign rep_i    = VW'(rep_reg);
    assign time_inc = (time_reg < TIME_MAX) ? time_reg + TIME_W'(1) : time_reg;
    assign out_free = !out_valid_reg || res.ready;

    // neighbour slot of the vertex being expanded
    assign nbr_raddr = NAW'(cur_reg) * NAW'(MAX_DEGREE) + NAW'(nbi_reg);

    // any present vertex above the one being reported (for the last flag)
    always_comb
    begin
        any_above = 1'b0;
        for (int k = 0; k < REP_N; k++)
        begin
            if (32'(k) > 32'(rep_reg) && present_reg[k])
            begin
                any_above = 1'b1;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        root_next      = root_reg;
        cur_next       = cur_reg;
        nbi_next       = nbi_reg;
        pushed_next    = pushed_reg;
        time_next      = time_reg;
        rep_next       = rep_reg;
        present_next   = present_reg;
        visited_next   = visited_reg;
        finished_next  = finished_reg;
        len_next       = len_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg && !res.ready;
        node_next      = node_reg;
        first_next     = first_reg;
        fin_next       = fin_reg;
        drop_out_next  = drop_out_reg;
        last_next      = last_reg;
        nbr_we         = 1'b0;
        nbr_waddr      = NAW'(cmd_v) * NAW'(MAX_DEGREE) + NAW'(len_reg[cmd_v]);
        disc_we        = 1'b0;
        fin_we         = 1'b0;
        stk_ctl        = '0;
        stk_wdata      = root_i;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd.kind)
                        KIND_ADD:
                        begin
                            if (cmd_v_ok)
                            begin
                                present_next[cmd_v] = 1'b1;
                                len_next[cmd_v]     = '0;
                            end
                        end
                        KIND_EDGE:
                        begin
                            if (cmd_v_ok && cmd_n_ok)
                            begin
                                if (len_reg[cmd_v] < DEG_MAX)
                                begin
                                    nbr_we          = 1'b1;
                                    len_next[cmd_v] = len_reg[cmd_v] + LW'(1);
                                end
                                else
                                begin
                                    dropped_next = 1'b1;
                                end
                            end
                        end
                        KIND_RUN:
                        begin
                            visited_next  = '0;
                            finished_next = '0;
                            stk_ctl.clear = 1'b1;
                            time_next     = '0;
                            root_next     = '0;
                            state_next    = ST_ROOT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // pick the next unvisited present vertex as a root
            ST_ROOT:
            begin
                if (root_reg == ROOT_END)
                begin
                    rep_next   = '0;
                    state_next = ST_REP_SCAN;
                end
                else if (present_reg[root_i] && !visited_reg[root_i])
                begin
                    stk_ctl.push = 1'b1;
                    stk_wdata    = root_i;
                    state_next   = ST_TOP_RD;
                end
                else
                begin
                    root_next = root_reg + (VW+1)'(1);
                end
            end

            // top entry read in flight
            ST_TOP_RD:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                cur_next = stk_top;
                if (!visited_reg[stk_top])
                begin
                    visited_next[stk_top] = 1'b1;
                    nbi_next              = '0;
                    pushed_next           = 1'b0;
                    state_next            = ST_NB_RD;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end

            // step through the neighbour list
            ST_NB_RD:
            begin
                if (nbi_reg == len_reg[cur_reg])
                begin
                    state_next = ST_DISC;
                end
                else
                begin
                    state_next = ST_NB_CHK;
                end
            end

            ST_NB_CHK:
            begin
                if (!visited_reg[nbr_q])
                begin
                    stk_ctl.push = 1'b1;
                    stk_wdata    = nbr_q;
                    pushed_next  = 1'b1;
                end
                nbi_next   = nbi_reg + LW'(1);
                state_next = ST_NB_RD;
            end

            // discovery time for a freshly visited vertex
            ST_DISC:
            begin
                disc_we    = 1'b1;
                time_next  = time_inc;
                state_next = pushed_reg ? ST_TOP_RD : ST_POP;
            end

            // pop and stamp the finish time once
            ST_POP:
            begin
                stk_ctl.pop = 1'b1;
                if (!finished_reg[cur_reg])
                begin
                    finished_next[cur_reg] = 1'b1;
                    fin_we                 = 1'b1;
                    time_next              = time_inc;
                end
                state_next = stk_sts.single ? ST_ROOT : ST_TOP_RD;
            end

            // report present vertices in index order
            ST_REP_SCAN:
            begin
                if (rep_reg == REP_END)
                begin
                    state_next = ST_IDLE;
                end
                else if (present_reg[rep_i])
                begin
                    state_next = ST_REP_LOAD;
                end
                else
                begin
                    rep_next = rep_reg + RW'(1);
                end
            end

            ST_REP_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    node_next      = IDX_W'(rep_reg);
                    first_next     = visited_reg[rep_i] ? disc_q : '0;
                    fin_next       = finished_reg[rep_i] ? fin_q : '0;
                    drop_out_next  = dropped_reg;
                    last_next      = !any_above;
                    rep_next       = rep_reg + RW'(1);
                    state_next     = ST_REP_SCAN;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            root_reg      <= '0;
            cur_reg       <= '0;
            nbi_reg       <= '0;
            pushed_reg    <= 1'b0;
            time_reg      <= '0;
            rep_reg       <= '0;
            present_reg   <= '0;
            visited_reg   <= '0;
            finished_reg  <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < VERTICES; k++)
            begin
                len_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            root_reg      <= root_next;
            cur_reg       <= cur_next;
            nbi_reg       <= nbi_next;
            pushed_reg    <= pushed_next;
            time_reg      <= time_next;
            rep_reg       <= rep_next;
            present_reg   <= present_next;
            visited_reg   <= visited_next;
            finished_reg  <= finished_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        first_reg    <= first_next;
        fin_reg      <= fin_next;
        drop_out_reg <= drop_out_next;
        last_reg     <= last_next;
    end

    // neighbour table
    always_ff @(posedge clk)
    begin
        if (nbr_we)
        begin
            nbr_mem[nbr_waddr] <= cmd_n;
        end
        nbr_q <= nbr_mem[nbr_raddr];
    end

    // timestamp tables, valid bits live in visited/finished
    always_ff @(posedge clk)
    begin
        if (disc_we)
        begin
            disc_mem[cur_reg] <= time_inc;
        end
        if (fin_we)
        begin
            fin_mem[cur_reg] <= time_inc;
        end
        disc_q <= disc_mem[rep_i];
        fin_q  <= fin_mem[rep_i];
    end

    assign cmd.ready         = (state_reg == ST_IDLE);
    assign res.valid         = out_valid_reg;
    assign res.node          = node_reg;
    assign res.first_seen    = first_reg;
    assign res.finished      = fin_reg;
    assign res.edges_dropped = drop_out_reg;
    assign res.last          = last_reg;

endmodule
